FILE: rtl/core/aavr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_pkg
// Shared constants and helpers for the axis-angle vector rotation unit.
// ----------------------------------------------------------------------------
package aavr_pkg;

    localparam int ANG_W = 40;
    localparam int Q30_W = 36;
    localparam logic signed [Q30_W-1:0] ONE_Q30   = 36'sd1073741824;
    localparam logic signed [Q30_W-1:0] HALF_Q30  = 36'sd536870912;
    localparam logic signed [Q30_W-1:0] CORDIC_X0 = 36'sd652032874;

    function automatic logic signed [ANG_W-1:0] atan_q28(input logic [4:0] idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            5'd0:  r = 40'sd12079595520;
            5'd1:  r = 40'sd7131001626;
            5'd2:  r = 40'sd3767825416;
            5'd3:  r = 40'sd1912607013;
            5'd4:  r = 40'sd960014949;
            5'd5:  r = 40'sd480475470;
            5'd6:  r = 40'sd240296363;
            5'd7:  r = 40'sd120155514;
            5'd8:  r = 40'sd60078674;
            5'd9:  r = 40'sd30039451;
            5'd10: r = 40'sd15019740;
            5'd11: r = 40'sd7509872;
            5'd12: r = 40'sd3754936;
            5'd13: r = 40'sd1877468;
            5'd14: r = 40'sd938734;
            5'd15: r = 40'sd469367;
            5'd16: r = 40'sd234684;
            5'd17: r = 40'sd117342;
            5'd18: r = 40'sd58671;
            5'd19: r = 40'sd29335;
            5'd20: r = 40'sd14668;
            5'd21: r = 40'sd7334;
            5'd22: r = 40'sd3667;
            5'd23: r = 40'sd1833;
            5'd24: r = 40'sd917;
            5'd25: r = 40'sd458;
            5'd26: r = 40'sd229;
            5'd27: r = 40'sd115;
            5'd28: r = 40'sd57;
            5'd29: r = 40'sd29;
            5'd30: r = 40'sd14;
            default: r = 40'sd7;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/aavr_mulq30.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_mulq30
// Registered Q30 product: floor((a*b + 2^29) / 2^30).
// ----------------------------------------------------------------------------
module aavr_mulq30 #(
    parameter int AW = 36,
    parameter int BW = 36,
    parameter int PW = 50
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [PW-1:0] p
);

    logic signed [AW+BW-1:0] prod;
    logic signed [PW-1:0]    p_reg;

    assign prod = a * b + (AW+BW)'(aavr_pkg::HALF_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= PW'(prod >>> 30);
        end
    end

    assign p = p_reg;

endmodule

FILE: rtl/core/aavr_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_cordic
// Angle reduction and pipelined rotation CORDIC, one stage per register.
// The modulo-360 reduction is a chain of compare-subtract stages.
// Side data (vector, axis) rides along with each item.
// ----------------------------------------------------------------------------
module aavr_cordic #(
    parameter int COMP_WIDTH    = 32,
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 24,
    parameter int SW            = 192
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [COMP_WIDTH-1:0]          angle,
    input  logic [SW-1:0]                         side_in,
    output logic                                  out_valid,
    output logic signed [aavr_pkg::Q30_W-1:0]     cos_q30,
    output logic signed [aavr_pkg::Q30_W-1:0]     sin_q30,
    output logic [SW-1:0]                         side_out
);

    localparam int QW = aavr_pkg::Q30_W;
    localparam int AW = aavr_pkg::ANG_W;
    localparam int QB = (COMP_WIDTH - FRAC_BITS - 9 > 0) ? COMP_WIDTH - FRAC_BITS - 9 : 0;
    localparam int RW = ((COMP_WIDTH > FRAC_BITS + 9) ? COMP_WIDTH : FRAC_BITS + 9) + 2;
    localparam int ZL = (FRAC_BITS <= 28) ? 28 - FRAC_BITS : 0;
    localparam int ZR = (FRAC_BITS > 28) ? FRAC_BITS - 28 : 0;
    localparam int N  = CORDIC_STAGES;

    localparam logic signed [RW-1:0] FULL     = RW'(360) <<< FRAC_BITS;
    localparam logic signed [RW-1:0] HALF     = RW'(180) <<< FRAC_BITS;
    localparam logic signed [RW-1:0] QUARTER  = RW'(90) <<< FRAC_BITS;
    localparam logic signed [RW-1:0] FULL_TOP = RW'(360) <<< (FRAC_BITS + QB);

    // stage 0: lift negative angles by a multiple of 360
    logic signed [RW-1:0] a_ext, rem0;
    logic signed [RW-1:0] r0_reg;
    logic                 v0_reg;
    logic [SW-1:0]        s0_reg;

    assign a_ext = RW'(angle);
    assign rem0  = (a_ext < 0) ? a_ext + FULL_TOP : a_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg <= rem0;
            s0_reg <= side_in;
        end
    end

    // modulo 360: subtract 360 * 2^k when it fits, highest k first
    logic signed [RW-1:0] q_reg  [QB+1];
    logic                 qv_reg [QB+1];
    logic [SW-1:0]        qs_reg [QB+1];

    assign q_reg[0]  = r0_reg;
    assign qv_reg[0] = v0_reg;
    assign qs_reg[0] = s0_reg;

    for (genvar i = 0; i < QB; i++)
    begin : g_mod
        localparam logic signed [RW-1:0] STEP = RW'(360) <<< (FRAC_BITS + QB - 1 - i);
        logic signed [RW-1:0] r_q;
        logic                 v_q;
        logic [SW-1:0]        s_q;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_q <= 1'b0;
            end
            else if (en)
            begin
                v_q <= qv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_q <= (q_reg[i] >= STEP) ? q_reg[i] - STEP : q_reg[i];
                s_q <= qs_reg[i];
            end
        end

        assign q_reg[i+1]  = r_q;
        assign qv_reg[i+1] = v_q;
        assign qs_reg[i+1] = s_q;
    end

    // stage 1: fold into [-90, 90]
    logic signed [RW-1:0] r1, r2;
    logic                 neg1;
    logic signed [AW-1:0] z_init;
    logic signed [AW-1:0] z1_reg;
    logic                 n1_reg, v1_reg;
    logic [SW-1:0]        s1_reg;

    always_comb
    begin
        r1 = q_reg[QB];
        if (r1 >= HALF)
        begin
            r1 = r1 - FULL;
        end
        neg1 = 1'b0;
        r2   = r1;
        if (r1 > QUARTER)
        begin
            r2   = r1 - HALF;
            neg1 = 1'b1;
        end
        else if (r1 < -QUARTER)
        begin
            r2   = r1 + HALF;
            neg1 = 1'b1;
        end
        z_init = AW'(r2 >>> ZR) <<< ZL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= qv_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z1_reg <= z_init;
            n1_reg <= neg1;
            s1_reg <= qs_reg[QB];
        end
    end

    // rotation stages
    logic signed [QW-1:0] x_reg [N+1];
    logic signed [QW-1:0] y_reg [N+1];
    logic signed [AW-1:0] z_reg [N+1];
    logic                 n_reg [N+1];
    logic                 v_reg [N+1];
    logic [SW-1:0]        s_reg [N+1];

    assign x_reg[0] = aavr_pkg::CORDIC_X0;
    assign y_reg[0] = '0;
    assign z_reg[0] = z1_reg;
    assign n_reg[0] = n1_reg;
    assign v_reg[0] = v1_reg;
    assign s_reg[0] = s1_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [QW-1:0] dx, dy;
        logic signed [AW-1:0] at;
        logic signed [QW-1:0] x_q, y_q;
        logic signed [AW-1:0] z_q;
        logic                 n_q, v_q;
        logic [SW-1:0]        s_q;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = aavr_pkg::atan_q28(5'(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_q <= 1'b0;
            end
            else if (en)
            begin
                v_q <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_q <= x_reg[i] - dx;
                    y_q <= y_reg[i] + dy;
                    z_q <= z_reg[i] - at;
                end
                else
                begin
                    x_q <= x_reg[i] + dx;
                    y_q <= y_reg[i] - dy;
                    z_q <= z_reg[i] + at;
                end
                n_q <= n_reg[i];
                s_q <= s_reg[i];
            end
        end

        assign x_reg[i+1] = x_q;
        assign y_reg[i+1] = y_q;
        assign z_reg[i+1] = z_q;
        assign n_reg[i+1] = n_q;
        assign v_reg[i+1] = v_q;
        assign s_reg[i+1] = s_q;
    end

    assign cos_q30   = n_reg[N] ? -x_reg[N] : x_reg[N];
    assign sin_q30   = n_reg[N] ? -y_reg[N] : y_reg[N];
    assign out_valid = v_reg[N];
    assign side_out  = s_reg[N];

endmodule

FILE: rtl/core/aavr_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_matrix
// Rodrigues matrix terms, matrix-vector product and saturation.
// Five register stages; stages A, B and D each hold one multiplier level.
// ----------------------------------------------------------------------------
module aavr_matrix #(
    parameter int COMP_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [aavr_pkg::Q30_W-1:0] cos_q30,
    input  logic signed [aavr_pkg::Q30_W-1:0] sin_q30,
    input  logic signed [COMP_WIDTH-1:0]      vx,
    input  logic signed [COMP_WIDTH-1:0]      vy,
    input  logic signed [COMP_WIDTH-1:0]      vz,
    input  logic signed [COMP_WIDTH-1:0]      ax_raw,
    input  logic signed [COMP_WIDTH-1:0]      ay_raw,
    input  logic signed [COMP_WIDTH-1:0]      az_raw,
    output logic                              out_valid,
    output logic signed [COMP_WIDTH-1:0]      rx,
    output logic signed [COMP_WIDTH-1:0]      ry,
    output logic signed [COMP_WIDTH-1:0]      rz,
    output logic                              sat
);

    localparam int QW = aavr_pkg::Q30_W;
    localparam int CW = COMP_WIDTH;
    localparam int MW = 40;
    localparam int EW = MW + CW;
    localparam int SW = EW + 2;

    // axis to Q2.30
    logic signed [QW-1:0] ax, ay, az;
    if (CW >= 32)
    begin : g_ashr
        assign ax = QW'(ax_raw >>> (CW - 32));
        assign ay = QW'(ay_raw >>> (CW - 32));
        assign az = QW'(az_raw >>> (CW - 32));
    end
    else
    begin : g_ashl
        assign ax = QW'(ax_raw) <<< (32 - CW);
        assign ay = QW'(ay_raw) <<< (32 - CW);
        assign az = QW'(az_raw) <<< (32 - CW);
    end

    logic [4:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // stage A: axis products, s*a; carry c, t, vector
    logic signed [QW-1:0] pxx, pyy, pzz, pxy, pxz, pyz, sx, sy, sz;
    logic signed [QW-1:0] t_in;
    logic signed [QW-1:0] ca_reg, ta_reg;
    logic signed [CW-1:0] va_reg [3];

    assign t_in = aavr_pkg::ONE_Q30 - cos_q30;

    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_pxx (.clk, .en, .a(ax), .b(ax), .p(pxx));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_pyy (.clk, .en, .a(ay), .b(ay), .p(pyy));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_pzz (.clk, .en, .a(az), .b(az), .p(pzz));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_pxy (.clk, .en, .a(ax), .b(ay), .p(pxy));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_pxz (.clk, .en, .a(ax), .b(az), .p(pxz));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_pyz (.clk, .en, .a(ay), .b(az), .p(pyz));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_sx  (.clk, .en, .a(sin_q30), .b(ax), .p(sx));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_sy  (.clk, .en, .a(sin_q30), .b(ay), .p(sy));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_sz  (.clk, .en, .a(sin_q30), .b(az), .p(sz));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg    <= cos_q30;
            ta_reg    <= t_in;
            va_reg[0] <= vx;
            va_reg[1] <= vy;
            va_reg[2] <= vz;
        end
    end

    // stage B: t * axis products
    logic signed [QW-1:0] txx, tyy, tzz, txy, txz, tyz;
    logic signed [QW-1:0] cb_reg, sxb_reg, syb_reg, szb_reg;
    logic signed [CW-1:0] vb_reg [3];

    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_txx (.clk, .en, .a(ta_reg), .b(pxx), .p(txx));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_tyy (.clk, .en, .a(ta_reg), .b(pyy), .p(tyy));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_tzz (.clk, .en, .a(ta_reg), .b(pzz), .p(tzz));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_txy (.clk, .en, .a(ta_reg), .b(pxy), .p(txy));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_txz (.clk, .en, .a(ta_reg), .b(pxz), .p(txz));
    aavr_mulq30 #(.AW(QW), .BW(QW), .PW(QW)) u_tyz (.clk, .en, .a(ta_reg), .b(pyz), .p(tyz));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cb_reg  <= ca_reg;
            sxb_reg <= sx;
            syb_reg <= sy;
            szb_reg <= sz;
            vb_reg  <= va_reg;
        end
    end

    // stage C: matrix terms
    logic signed [MW-1:0] m_reg [3][3];
    logic signed [CW-1:0] vc_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0][0] <= MW'(cb_reg) + MW'(txx);
            m_reg[0][1] <= MW'(txy) - MW'(szb_reg);
            m_reg[0][2] <= MW'(txz) + MW'(syb_reg);
            m_reg[1][0] <= MW'(txy) + MW'(szb_reg);
            m_reg[1][1] <= MW'(cb_reg) + MW'(tyy);
            m_reg[1][2] <= MW'(tyz) - MW'(sxb_reg);
            m_reg[2][0] <= MW'(txz) - MW'(syb_reg);
            m_reg[2][1] <= MW'(tyz) + MW'(sxb_reg);
            m_reg[2][2] <= MW'(cb_reg) + MW'(tzz);
            vc_reg      <= vb_reg;
        end
    end

    // stage D: term * vector
    logic signed [EW-1:0] pr [3][3];

    for (genvar k = 0; k < 3; k++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            aavr_mulq30 #(.AW(MW), .BW(CW), .PW(EW)) u_mv (
                .clk, .en, .a(m_reg[k][j]), .b(vc_reg[j]), .p(pr[k][j]));
        end
    end

    // stage E: sum and clip
    localparam logic signed [SW-1:0] HI = SW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);

    logic signed [SW-1:0] acc  [3];
    logic signed [CW-1:0] clip [3];
    logic [2:0]           clipped;
    logic signed [CW-1:0] r_reg [3];
    logic                 sat_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc[k] = SW'(pr[k][0]) + SW'(pr[k][1]) + SW'(pr[k][2]);
            if (acc[k] > HI)
            begin
                clip[k] = CW'(HI);
                clipped[k] = 1'b1;
            end
            else if (acc[k] < LO)
            begin
                clip[k] = CW'(LO);
                clipped[k] = 1'b1;
            end
            else
            begin
                clip[k] = CW'(acc[k]);
                clipped[k] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= clip;
            sat_reg <= |clipped;
        end
    end

    assign rx        = r_reg[0];
    assign ry        = r_reg[1];
    assign rz        = r_reg[2];
    assign sat       = sat_reg;
    assign out_valid = v_reg[4];

endmodule

FILE: rtl/core/axis_angle_vector_rotation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_unit
// Rotates a vector about an axis by an angle in degrees (Rodrigues).
//
// s_axis: one request per transfer carrying vector, axis and angle.
// m_axis: one result per request: rotated vector and a saturation flag.
// Path: stage-0 register, QB = COMP_WIDTH - FRAC_BITS - 9 (at least 0)
// modulo-360 stages, fold register, CORDIC_STAGES rotation stages and the
// matrix stages. Throughput: one request per clock while not held.
// The whole pipeline advances together; when m_axis_tready is low while
// a result waits, all stages hold and s_axis_tready drops, so nothing is
// lost or repeated. An empty output slot lets the pipe advance.
// Reset clears all valid bits; payload registers are not reset.
// Rate is set by the registered CORDIC stages and multipliers.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_unit #(
    parameter int COMP_WIDTH    = 32,
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle_deg (low to high)
    input  logic [7*COMP_WIDTH-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // rot_x, rot_y, rot_z (low to high)
    output logic [3*COMP_WIDTH-1:0] m_axis_tdata,
    // saturated
    output logic                    m_axis_tuser
);

    localparam int CW = COMP_WIDTH;
    localparam int SW = 6 * CW;
    localparam int QW = aavr_pkg::Q30_W;

    logic en;
    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    logic                 cv;
    logic signed [QW-1:0] c, s;
    logic [SW-1:0]        side;

    aavr_cordic #(
        .COMP_WIDTH(CW), .FRAC_BITS(FRAC_BITS),
        .CORDIC_STAGES(CORDIC_STAGES), .SW(SW)
    ) u_cordic (
        .clk, .rst_n, .en,
        .in_valid (s_axis_tvalid),
        .angle    (s_axis_tdata[6*CW +: CW]),
        .side_in  (s_axis_tdata[SW-1:0]),
        .out_valid(cv),
        .cos_q30  (c),
        .sin_q30  (s),
        .side_out (side)
    );

    logic signed [CW-1:0] rx, ry, rz;

    aavr_matrix #(.COMP_WIDTH(CW)) u_matrix (
        .clk, .rst_n, .en,
        .in_valid (cv),
        .cos_q30  (c),
        .sin_q30  (s),
        .vx       (side[0*CW +: CW]),
        .vy       (side[1*CW +: CW]),
        .vz       (side[2*CW +: CW]),
        .ax_raw   (side[3*CW +: CW]),
        .ay_raw   (side[4*CW +: CW]),
        .az_raw   (side[5*CW +: CW]),
        .out_valid(m_axis_tvalid),
        .rx, .ry, .rz,
        .sat      (m_axis_tuser)
    );

    assign m_axis_tdata = {rz, ry, rx};

endmodule

FILE: sim/aavr_rotation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aavr_rotation_checker
// Watches both stream channels of the rotation unit, computes the expected
// rotated vector and saturation flag for every accepted request, and
// compares each accepted result against the oldest pending expectation.
// ----------------------------------------------------------------------------
module aavr_rotation_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [223:0] s_axis_tdata,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [95:0] m_axis_tdata,
    input  logic       m_axis_tuser,
    output int         fail_count,
    output int         pending,
    output int         sat_seen
);

    typedef struct packed {
        logic        sat;
        logic [31:0] rz;
        logic [31:0] ry;
        logic [31:0] rx;
    } rot_result_t;

    rot_result_t rot_queue[$];

    // floor((a*b + 2^29) / 2^30), split to stay within 64 bits
    function automatic longint qmul(longint a, longint b);
        longint bh, bl, hi, lo;
        bh = b >>> 24;
        bl = b - bh * 64'sd16777216;
        hi = a * bh;
        lo = a * bl + 64'sd536870912;
        return (hi + (lo >>> 24)) >>> 6;
    endfunction

    function automatic rot_result_t rotate_vector(logic [223:0] d);
        longint v[3], ax, ay, az, r, z, x, y, c, s, t, dx, dy, acc, ang;
        longint axx, ayy, azz, axy, axz, ayz, sx, sy, sz;
        longint m[3][3];
        longint full, half, quarter;
        logic [31:0] o[3];
        bit neg, sat;
        rot_result_t res;
        full = 360 * 65536;
        half = 180 * 65536;
        quarter = 90 * 65536;
        neg = 0;
        sat = 0;
        for (int i = 0; i < 3; i++)
            v[i] = longint'($signed(d[32*i +: 32]));
        ax = longint'($signed(d[96 +: 32]));
        ay = longint'($signed(d[128 +: 32]));
        az = longint'($signed(d[160 +: 32]));
        ang = longint'($signed(d[192 +: 32]));
        r = ang % full;
        if (r < 0) r += full;
        if (r >= half) r -= full;
        if (r > quarter) begin r -= half; neg = 1; end
        else if (r < -quarter) begin r += half; neg = 1; end
        z = r * 4096;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(aavr_pkg::atan_q28(i[4:0]));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(aavr_pkg::atan_q28(i[4:0]));
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
        t = 64'sd1073741824 - c;
        axx = qmul(t, qmul(ax, ax));
        ayy = qmul(t, qmul(ay, ay));
        azz = qmul(t, qmul(az, az));
        axy = qmul(t, qmul(ax, ay));
        axz = qmul(t, qmul(ax, az));
        ayz = qmul(t, qmul(ay, az));
        sx = qmul(s, ax);
        sy = qmul(s, ay);
        sz = qmul(s, az);
        m[0][0] = c + axx; m[0][1] = axy - sz; m[0][2] = axz + sy;
        m[1][0] = axy + sz; m[1][1] = c + ayy; m[1][2] = ayz - sx;
        m[2][0] = axz - sy; m[2][1] = ayz + sx; m[2][2] = c + azz;
        for (int k = 0; k < 3; k++)
        begin
            acc = qmul(m[k][0], v[0]) + qmul(m[k][1], v[1]) + qmul(m[k][2], v[2]);
            if (acc > 64'sd2147483647) begin acc = 64'sd2147483647; sat = 1; end
            if (acc < -64'sd2147483648) begin acc = -64'sd2147483648; sat = 1; end
            o[k] = acc[31:0];
        end
        res.rx = o[0];
        res.ry = o[1];
        res.rz = o[2];
        res.sat = sat;
        return res;
    endfunction

    initial
    begin
        fail_count = 0;
        sat_seen = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        rot_result_t want;
        rot_result_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                rot_queue.push_back(rotate_vector(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata};
                if (got.sat) sat_seen++;
                if (rot_queue.size() == 0)
                begin
                    $display("%0t: unexpected result rot=%h sat=%b", $time,
                             m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    want = rot_queue.pop_front();
                    if (got.rx !== want.rx)
                    begin
                        $display("%0t: rot_x exp %h got %h", $time, want.rx, got.rx);
                        fail_count++;
                    end
                    if (got.ry !== want.ry)
                    begin
                        $display("%0t: rot_y exp %h got %h", $time, want.ry, got.ry);
                        fail_count++;
                    end
                    if (got.rz !== want.rz)
                    begin
                        $display("%0t: rot_z exp %h got %h", $time, want.rz, got.rz);
                        fail_count++;
                    end
                    if (got.sat !== want.sat)
                    begin
                        $display("%0t: saturated exp %b got %b", $time, want.sat, got.sat);
                        fail_count++;
                    end
                end
            end
        end
        pending <= rot_queue.size();
    end
endmodule

FILE: sim/tb_axis_angle_vector_rotation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_angle_vector_rotation_unit
// Streams directed and random rotation requests into the unit with random
// gaps on both sides; a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_axis_angle_vector_rotation_unit;
    localparam int ONE = 65536;
    localparam int UNIT = 32'h4000_0000;
    localparam int N_RANDOM = 1800;
    localparam longint CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [223:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;
    int           fail_count;
    int           pending;
    int           sat_seen;
    int           n_sent;
    longint       cycles;

    axis_angle_vector_rotation_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    aavr_rotation_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count), .pending(pending), .sat_seen(sat_seen)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result-side stalls
    initial
    begin
        int g;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            m_axis_tready <= 1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            g = gap_len();
            if (g > 0)
            begin
                m_axis_tready <= 0;
                repeat (g) @(posedge clk);
            end
        end
    end

    task automatic send_request(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                logic [31:0] ang, bit idle_ok);
        int g;
        g = idle_ok ? gap_len() : 0;
        if (g > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {ang, az, ay, ax, vz, vy, vx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        n_sent++;
    endtask

    function automatic logic [31:0] rnd_axis(int mode);
        logic [31:0] r;
        r = $urandom;
        case (mode)
            0: return $urandom_range(0, 1) ? UNIT : -UNIT;
            1: return {{3{r[31]}}, r[28:0]};
            default: return r;
        endcase
    endfunction

    initial
    begin
        logic [31:0] vx, vy, vz, ax, ay, az, ang;
        int k;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        n_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: axes, quadrant folds, negative and huge angles, extremes
        send_request(ONE, 0, 0, 0, 0, UNIT, 90 * ONE, 0);
        send_request(ONE, 2 * ONE, 3 * ONE, UNIT, 0, 0, 180 * ONE, 0);
        send_request(ONE, 2 * ONE, 3 * ONE, 0, UNIT, 0, 270 * ONE, 0);
        send_request(ONE, 2 * ONE, 3 * ONE, 0, 0, UNIT, -90 * ONE, 0);
        send_request(ONE, ONE, ONE, 0, 0, UNIT, 0, 0);
        send_request(ONE, ONE, ONE, 0, 0, UNIT, 360 * ONE, 0);
        send_request(ONE, ONE, ONE, 0, 0, UNIT, -720 * ONE - 1, 0);
        send_request(ONE, ONE, ONE, UNIT, 0, 0, 91 * ONE, 0);
        send_request(ONE, ONE, ONE, UNIT, 0, 0, -91 * ONE, 0);
        send_request(ONE, ONE, ONE, UNIT, 0, 0, 180 * ONE + 1, 0);
        send_request(ONE, ONE, ONE, UNIT, 0, 0, 32'h7fff_ffff, 0);
        send_request(ONE, ONE, ONE, UNIT, 0, 0, 32'h8000_0000, 0);
        send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 45 * ONE, 0);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 135 * ONE, 0);
        send_request(32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000, 0, 0, 0, 0);
        send_request(32'h7fff_ffff, 0, 32'h8000_0000, 0, 32'h7fff_ffff, 0, 60 * ONE, 0);
        send_request(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff,
                     32'hffff_ffff, 1, 0, 32'hffff_ffff, 0);
        send_request(32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, UNIT, 45 * ONE, 0);

        for (k = 0; k < N_RANDOM; k++)
        begin
            int mode;
            mode = $urandom_range(0, 9) < 7 ? 1 : ($urandom_range(0, 1) ? 0 : 2);
            vx = $urandom_range(0, 3) == 0 ? $urandom : {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
            vy = $urandom_range(0, 3) == 0 ? $urandom : {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
            vz = $urandom_range(0, 3) == 0 ? $urandom : {{8{1'b0}}, 24'($urandom)} - 32'h0080_0000;
            ax = rnd_axis(mode);
            ay = rnd_axis(mode);
            az = rnd_axis(mode);
            ang = $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 720 * ONE) - 360 * ONE);
            send_request(vx, vy, vz, ax, ay, az, ang, k > 50);
            if (k == N_RANDOM / 2)
            begin
                s_axis_tvalid <= 0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
        end
        s_axis_tvalid <= 0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d rotation requests (quadrant folds, wide angles, extreme fields)",
                 n_sent);
        $display("with random stalls on both sides; %0d results came back saturated.",
                 sat_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: axis_angle_vector_rotation_unit.f
rtl/core/aavr_pkg.sv
rtl/core/aavr_mulq30.sv
rtl/core/aavr_cordic.sv
rtl/core/aavr_matrix.sv
rtl/core/axis_angle_vector_rotation_unit.sv
sim/aavr_rotation_checker.sv
sim/tb_axis_angle_vector_rotation_unit.sv
